>>> rtl/core/qdcs_pkg.sv
`timescale 1ns / 1ps

package qdcs_pkg;

	localparam int TICK_W  = 31;
	localparam int TPQ_W   = 16;
	localparam int SND_W   = 16;
	localparam int MASK_W  = 16;
	localparam int BPB_W   = 8;
	localparam int GRID_W  = TPQ_W + BPB_W;
	localparam int HOLD_W  = 24;
	localparam int TRIG_W  = 17;
	localparam int REM_CNT_W = 5;

	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

	// configuration register indexes
	localparam logic [2:0] REG_ENABLED       = 3'd0;
	localparam logic [2:0] REG_QUANT_MODE    = 3'd1;
	localparam logic [2:0] REG_BEATS_PER_BAR = 3'd2;
	localparam logic [2:0] REG_TRIGGER_SOUND = 3'd3;
	localparam logic [2:0] REG_MASK_FULL     = 3'd4;
	localparam logic [2:0] REG_MASK_DUCKED   = 3'd5;
	localparam logic [2:0] REG_HOLD_TICKS    = 3'd6;

	// landing grid codes
	localparam logic [1:0] QUANT_NOW  = 2'd0;
	localparam logic [1:0] QUANT_BEAT = 2'd1;
	localparam logic [1:0] QUANT_BAR  = 2'd2;

	localparam logic [BPB_W-1:0] BPB_DEFAULT = 8'd4;

	// item kinds
	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_SOUND = 1'b1;

	typedef struct packed {
		logic                      enabled;
		logic [1:0]                quant_mode;
		logic [BPB_W-1:0]          beats_per_bar;
		logic signed [TRIG_W-1:0]  trigger_sound;
		logic [MASK_W-1:0]         mask_full;
		logic [MASK_W-1:0]         mask_ducked;
		logic [HOLD_W-1:0]         hold_ticks;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_HOLD,
		ST_GRID,
		ST_MOD,
		ST_LAND,
		ST_DONE
	} state_t;

endpackage

>>> rtl/core/qdcs_cfg_regs.sv
`timescale 1ns / 1ps

module qdcs_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [2:0]          wr_index,
	input  logic [23:0]         wr_data,
	output qdcs_pkg::cfg_t      cfg
);
	import qdcs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled       <= 1'b0;
			cfg_q.quant_mode    <= QUANT_BAR;
			cfg_q.beats_per_bar <= BPB_DEFAULT;
			cfg_q.trigger_sound <= '1;
			cfg_q.mask_full     <= 16'hffff;
			cfg_q.mask_ducked   <= 16'h0003;
			cfg_q.hold_ticks    <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_ENABLED:       cfg_q.enabled       <= wr_data[0];
				REG_QUANT_MODE:    cfg_q.quant_mode    <= wr_data[1:0];
				REG_BEATS_PER_BAR: cfg_q.beats_per_bar <= wr_data[BPB_W-1:0];
				REG_TRIGGER_SOUND: cfg_q.trigger_sound <= wr_data[TRIG_W-1:0];
				REG_MASK_FULL:     cfg_q.mask_full     <= wr_data[MASK_W-1:0];
				REG_MASK_DUCKED:   cfg_q.mask_ducked   <= wr_data[MASK_W-1:0];
				REG_HOLD_TICKS:    cfg_q.hold_ticks    <= wr_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/qdcs_rem_unit.sv
`timescale 1ns / 1ps

// restoring remainder, one dividend bit per cycle
module qdcs_rem_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [qdcs_pkg::TICK_W-1:0]   dividend,
	input  logic [qdcs_pkg::GRID_W-1:0]   divisor,
	output logic                          busy,
	output logic                          done,
	output logic [qdcs_pkg::GRID_W-1:0]   rem
);
	import qdcs_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [REM_CNT_W-1:0]  cnt_q;
	logic [TICK_W-1:0]     dvd_q;
	logic [GRID_W-1:0]     div_q;
	logic [GRID_W-1:0]     rem_q;
	logic [GRID_W:0]       trial;
	logic [GRID_W:0]       diff;

	assign trial = {rem_q, dvd_q[TICK_W-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= REM_CNT_W'(TICK_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TICK_W-2:0], 1'b0};
			rem_q <= diff[GRID_W] ? trial[GRID_W-1:0] : diff[GRID_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> rtl/core/quantised_duck_cue_scheduler.sv
`timescale 1ns / 1ps

// Ducking cue scheduler. Items come in on the s_axis channel: s_axis_tuser is the
// item kind (frame tick or sound event), s_axis_tdata carries the tick count,
// ticks per quarter and sound number. Every item gives exactly one result on the
// m_axis channel: m_axis_tuser flags a channel mask write, m_axis_tdata carries
// the mask and a snapshot of the scheduler state.
// Registers are written on the cfg channel (cfg_index, cfg_data), which is
// always ready; write only while no item is in flight.
// One item is in work at a time; s_axis_tready is low meanwhile and comes back
// the cycle after the result is registered. An item that schedules nothing goes
// through evaluation (and the hold check for a frame) to the result; an immediate
// cue adds the grid step, and a beat or bar aligned cue adds the modulo and landing
// steps: the landing boundary needs the tick count modulo the grid, found by one
// shared compare/subtract unit that handles one of the 31 tick bits per cycle.
// A finished result sits in the output register until taken; the next item is
// accepted meanwhile, and if its result is ready before the receiver takes the
// old one, the block waits with tready low.
// Reset (arst_n low) restores register defaults and clears all cue state; no
// memory clearing pass is needed.
module quantised_duck_cue_scheduler (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [63:0]   s_axis_tdata,   // now_tick[30:0], ticks_per_quarter[46:31],
	                                      // sound_number[62:47], zero[63]
	input  logic          s_axis_tuser,   // command
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [103:0]  m_axis_tdata,   // mask_value[15:0], cue_pending[16],
	                                      // cue_tick[47:17], is_ducked[48],
	                                      // hold_remaining[80:49], last_sound[97:81],
	                                      // zero[103:98]
	output logic          m_axis_tuser,   // mask_write
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [23:0]   cfg_data
);
	import qdcs_pkg::*;

	cfg_t cfg;

	state_t state_q, state_d;

	logic                     cmd_q;
	logic [TICK_W-1:0]        now_q;
	logic [TPQ_W-1:0]         tpq_q;
	logic [SND_W-1:0]         snd_q;

	logic                     pend_q;
	logic [TICK_W-1:0]        land_q;
	logic [MASK_W-1:0]        cue_mask_q;
	logic                     ducked_q;
	logic signed [31:0]       hold_q;
	logic signed [TRIG_W-1:0] last_snd_q;
	logic                     prev_vld_q;
	logic [TICK_W-1:0]        prev_q;

	logic [TICK_W-1:0]        delta_q;
	logic                     wrote_q;
	logic [MASK_W-1:0]        wval_q;
	logic [MASK_W-1:0]        sched_mask_q;
	logic [GRID_W-1:0]        grid_q;

	logic                     out_vld_q;
	logic                     out_wr_q;
	logic [97:0]              out_data_q;

	logic                     in_acc;
	logic                     out_load;
	logic                     trig_match;
	logic [TICK_W:0]          tick_diff;
	logic                     do_fire;
	logic [32:0]              hold_diff;
	logic signed [31:0]       hold_sat;
	logic                     hold_active;
	logic [BPB_W-1:0]         beats;
	logic [GRID_W-1:0]        grid_prod;
	logic                     grid_skip;
	logic [TICK_W+1:0]        land_sum;
	logic                     rem_start;
	logic                     rem_busy;
	logic                     rem_done;
	logic [GRID_W-1:0]        rem_val;

	assign cfg_ready = 1'b1;

	qdcs_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	qdcs_rem_unit u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (now_q),
		.divisor  (grid_prod),
		.busy     (rem_busy),
		.done     (rem_done),
		.rem      (rem_val)
	);

	// datapath terms
	assign trig_match  = cfg.trigger_sound[TRIG_W-1] ||
	                     ({1'b0, snd_q} == cfg.trigger_sound);
	assign tick_diff   = {1'b0, now_q} - {1'b0, prev_q};
	assign do_fire     = pend_q && ((prev_vld_q && tick_diff[TICK_W]) || (now_q >= land_q));
	assign hold_diff   = {hold_q[31], hold_q} - {2'b00, delta_q};
	assign hold_sat    = (hold_diff[32] && !hold_diff[31]) ? {1'b1, 31'd0} : hold_diff[31:0];
	assign hold_active = ducked_q && !pend_q && (cfg.hold_ticks != '0);
	assign beats       = (cfg.quant_mode != QUANT_BAR) ? BPB_W'(1) :
	                     (cfg.beats_per_bar == '0) ? BPB_DEFAULT : cfg.beats_per_bar;
	assign grid_prod   = GRID_W'(tpq_q) * GRID_W'(beats);
	assign grid_skip   = (cfg.quant_mode == QUANT_NOW) || (tpq_q == '0);
	assign land_sum    = {2'b00, now_q} + {{(TICK_W+2-GRID_W){1'b0}}, grid_q - rem_val};

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_load = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		rem_start     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (cmd_q == CMD_SOUND) begin
					if (cfg.enabled && trig_match && !ducked_q) state_d = ST_GRID;
					else state_d = ST_DONE;
				end else begin
					state_d = cfg.enabled ? ST_HOLD : ST_DONE;
				end
			end
			ST_HOLD: begin
				if (hold_active && (hold_sat[31] || hold_sat == '0)) state_d = ST_GRID;
				else state_d = ST_DONE;
			end
			ST_GRID: begin
				if (grid_skip) begin
					state_d = ST_DONE;
				end else begin
					rem_start = 1'b1;
					state_d   = ST_MOD;
				end
			end
			ST_MOD: begin
				if (rem_done) state_d = ST_LAND;
			end
			ST_LAND: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_vld_q || m_axis_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// input capture and scratch registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= s_axis_tuser;
			now_q <= s_axis_tdata[30:0];
			tpq_q <= s_axis_tdata[46:31];
			snd_q <= s_axis_tdata[62:47];
		end
		if (state_q == ST_EVAL) begin
			delta_q      <= (prev_vld_q && !tick_diff[TICK_W]) ? tick_diff[TICK_W-1:0] : '0;
			sched_mask_q <= (cmd_q == CMD_SOUND) ? cfg.mask_ducked : cfg.mask_full;
		end
		if (state_q == ST_GRID) grid_q <= grid_prod;
	end

	// scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= 1'b0;
			land_q     <= '0;
			cue_mask_q <= '0;
			ducked_q   <= 1'b0;
			hold_q     <= '0;
			last_snd_q <= '1;
			prev_vld_q <= 1'b0;
			prev_q     <= '0;
			wrote_q    <= 1'b0;
			wval_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						wrote_q <= 1'b0;
						wval_q  <= '0;
					end
				end
				ST_EVAL: begin
					if (cmd_q == CMD_SOUND) begin
						if (cfg.enabled) begin
							last_snd_q <= {1'b0, snd_q};
							if (trig_match && ducked_q)
								hold_q <= {8'd0, cfg.hold_ticks};
						end
					end else if (!cfg.enabled) begin
						prev_vld_q <= 1'b0;
					end else begin
						prev_vld_q <= 1'b1;
						prev_q     <= now_q;
						if (do_fire) begin
							ducked_q <= (cue_mask_q != cfg.mask_full);
							if (cue_mask_q != cfg.mask_full)
								hold_q <= {8'd0, cfg.hold_ticks};
							pend_q  <= 1'b0;
							wrote_q <= 1'b1;
							wval_q  <= cue_mask_q;
						end
					end
				end
				ST_HOLD: begin
					if (hold_active) hold_q <= hold_sat;
				end
				ST_GRID: begin
					if (grid_skip) begin
						land_q     <= now_q;
						pend_q     <= 1'b1;
						cue_mask_q <= sched_mask_q;
					end
				end
				ST_LAND: begin
					land_q     <= (land_sum > {2'b00, TICK_MAX}) ? TICK_MAX : land_sum[TICK_W-1:0];
					pend_q     <= 1'b1;
					cue_mask_q <= sched_mask_q;
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_wr_q   <= wrote_q;
			out_data_q <= {last_snd_q, hold_q, ducked_q, land_q, pend_q, wval_q};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_wr_q;
	assign m_axis_tdata  = {6'd0, out_data_q};

`ifndef SYNTHESIS
	a_rem_busy_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		rem_busy |-> (state_q == ST_MOD))
		else $error("remainder unit busy outside modulo phase");

	a_rem_below_grid: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> (rem_val < grid_q))
		else $error("remainder not below grid");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_EVAL))
		else $error("accepted item not evaluated");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[15:0] == '0))
		else $error("mask value set without mask write");

	a_land_after_now: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LAND) |=> (land_q > now_q || land_q == TICK_MAX))
		else $error("quantised cue does not land after now");
`endif

endmodule
